FILE: sv/sfk_pkg.sv
// ----------------------------------------------------------------------------
// sfk_pkg
// shared constants, inter-stage types and the cordic arctangent table
// ----------------------------------------------------------------------------
`default_nettype none

package sfk_pkg;

  // fixed-point formats
  localparam int FRAC_BITS  = 12;
  localparam int ANG_BITS   = 30;
  localparam int ANG_SHIFT  = ANG_BITS - FRAC_BITS;
  localparam int FIELD_W    = 16;
  localparam int SUM_W      = FIELD_W + 1;
  localparam int LEN_W      = 15;
  localparam int TRIG_W     = 14;
  localparam int RED_W      = 36;
  localparam int ANG_W      = 32;
  localparam int MAX_STAGES = 24;
  localparam int ONE_Q      = 1 << FRAC_BITS;

  // angle constants, q.30 radians
  localparam logic [RED_W-1:0] TWO_PI_Q      = 36'd6746518852;
  localparam logic [RED_W-1:0] PI_Q          = 36'd3373259426;
  localparam logic [RED_W-1:0] HALF_PI_Q     = 36'd1686629713;
  localparam logic [RED_W-1:0] PI_HALF_Q     = PI_Q + HALF_PI_Q;
  localparam logic [RED_W-1:0] TWO_PI_X2     = 36'd13493037704;
  localparam logic [RED_W-1:0] TWO_PI_X3     = 36'd20239556556;
  localparam logic [RED_W-1:0] TWO_PI_X4     = 36'd26986075408;
  localparam logic signed [ANG_W-1:0] GAIN_Q = 32'sd652032874;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_LINK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_LINK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = 2'd2;

  // reduced angles, both lanes, heading into the cordic
  typedef struct packed {
    logic signed [ANG_W-1:0]   ang_sum;
    logic signed [ANG_W-1:0]   ang0;
    logic                      neg_sum;
    logic                      neg0;
    logic signed [FIELD_W-1:0] pos_z;
  } sfk_angles_t;

  // rounded trig values, both lanes
  typedef struct packed {
    logic signed [TRIG_W-1:0]  cos_sum;
    logic signed [TRIG_W-1:0]  sin_sum;
    logic signed [TRIG_W-1:0]  cos0;
    logic signed [TRIG_W-1:0]  sin0;
    logic signed [FIELD_W-1:0] pos_z;
  } sfk_trig_t;

  // atan(2^-i) in q.30
  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      5'd0:    v = 32'sh3243F6A8;
      5'd1:    v = 32'sh1DAC6705;
      5'd2:    v = 32'sh0FADBAFC;
      5'd3:    v = 32'sh07F56EA6;
      5'd4:    v = 32'sh03FEAB76;
      5'd5:    v = 32'sh01FFD55B;
      5'd6:    v = 32'sh00FFFAAA;
      5'd7:    v = 32'sh007FFF55;
      5'd8:    v = 32'sh003FFFEA;
      5'd9:    v = 32'sh001FFFFD;
      5'd10:   v = 32'sh000FFFFF;
      5'd11:   v = 32'sh0007FFFF;
      5'd12:   v = 32'sh0003FFFF;
      5'd13:   v = 32'sh0001FFFF;
      5'd14:   v = 32'sh0000FFFF;
      5'd15:   v = 32'sh00007FFF;
      5'd16:   v = 32'sh00003FFF;
      5'd17:   v = 32'sh00001FFF;
      5'd18:   v = 32'sh00000FFF;
      5'd19:   v = 32'sh000007FF;
      5'd20:   v = 32'sh000003FF;
      5'd21:   v = 32'sh000001FF;
      5'd22:   v = 32'sh000000FF;
      5'd23:   v = 32'sh0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/sfk_angle_reduce.sv
// ----------------------------------------------------------------------------
// sfk_angle_reduce
// angle sum, modulo 2*pi reduction and fold into [-pi/2, pi/2], plus z
// ----------------------------------------------------------------------------
`default_nettype none

module sfk_angle_reduce (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire  signed [sfk_pkg::FIELD_W-1:0]     joint0_angle,
  input  wire  signed [sfk_pkg::FIELD_W-1:0]     joint1_angle,
  input  wire  signed [sfk_pkg::FIELD_W-1:0]     joint2_travel,
  input  wire  signed [sfk_pkg::FIELD_W-1:0]     height_offset,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output sfk_pkg::sfk_angles_t                   out_data
);

  localparam int S  = 5;
  localparam int RW = sfk_pkg::RED_W;
  localparam int AW = sfk_pkg::ANG_W;
  localparam int FW = sfk_pkg::FIELD_W;

  logic [S-1:0] vld;
  logic [S-1:0] vld_src;
  logic [S:0]   adv;

  // stage registers 0..3 hold the nonnegative reduction value of each lane
  logic [RW-1:0]        red_sum [0:3];
  logic [RW-1:0]        red_q0  [0:3];
  logic signed [FW-1:0] z_pipe  [0:3];

  logic signed [sfk_pkg::SUM_W-1:0] ang_sum;
  logic signed [sfk_pkg::SUM_W-1:0] ang_q0;
  logic signed [RW-1:0]             sum_ext;
  logic signed [RW-1:0]             q0_ext;
  logic signed [sfk_pkg::SUM_W-1:0] z_diff;
  logic signed [FW-1:0]             z_sat;

  function automatic logic [RW-1:0] cond_sub(input logic [RW-1:0] v,
                                             input logic [RW-1:0] m);
    return (v >= m) ? v - m : v;
  endfunction

  // fold [0, 2*pi) into [-pi/2, pi/2] with a negate flag
  function automatic logic [AW:0] fold(input logic [RW-1:0] r);
    logic [RW-1:0] d;
    logic          neg;
    if (r <= sfk_pkg::HALF_PI_Q) begin
      d   = r;
      neg = 1'b0;
    end else if (r < sfk_pkg::PI_HALF_Q) begin
      d   = r - sfk_pkg::PI_Q;
      neg = 1'b1;
    end else begin
      d   = r - sfk_pkg::TWO_PI_Q;
      neg = 1'b0;
    end
    return {neg, d[AW-1:0]};
  endfunction

  // handshake chain, a stage loads when empty or when its item moves on
  assign adv[S]   = out_ready;
  assign vld_src  = {vld[S-2:0], in_valid};
  assign in_ready = adv[0];
  assign out_valid = vld[S-1];

  for (genvar k = 0; k < S; k++) begin : g_adv
    assign adv[k] = ~vld[k] | adv[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < S; k++) begin
        if (adv[k]) begin
          vld[k] <= vld_src[k];
        end
      end
    end
  end

  // stage 0: angle to q.30, offset by three turns so the value is nonnegative
  always_comb begin
    ang_sum = sfk_pkg::SUM_W'(joint0_angle) + sfk_pkg::SUM_W'(joint1_angle);
    ang_q0  = sfk_pkg::SUM_W'(joint0_angle);
    sum_ext = RW'(ang_sum) <<< sfk_pkg::ANG_SHIFT;
    q0_ext  = RW'(ang_q0) <<< sfk_pkg::ANG_SHIFT;
    z_diff  = sfk_pkg::SUM_W'(height_offset) - sfk_pkg::SUM_W'(joint2_travel);
    if (z_diff > sfk_pkg::SUM_W'(17'sd32767)) begin
      z_sat = 16'sh7FFF;
    end else if (z_diff < -sfk_pkg::SUM_W'(17'sd32768)) begin
      z_sat = 16'sh8000;
    end else begin
      z_sat = z_diff[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      red_sum[0] <= $unsigned(sum_ext) + sfk_pkg::TWO_PI_X3;
      red_q0[0]  <= $unsigned(q0_ext) + sfk_pkg::TWO_PI_X3;
      z_pipe[0]  <= z_sat;
    end
  end

  // stages 1..3: remove four, two and one turns
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      red_sum[1] <= cond_sub(red_sum[0], sfk_pkg::TWO_PI_X4);
      red_q0[1]  <= cond_sub(red_q0[0], sfk_pkg::TWO_PI_X4);
      z_pipe[1]  <= z_pipe[0];
    end
    if (adv[2]) begin
      red_sum[2] <= cond_sub(red_sum[1], sfk_pkg::TWO_PI_X2);
      red_q0[2]  <= cond_sub(red_q0[1], sfk_pkg::TWO_PI_X2);
      z_pipe[2]  <= z_pipe[1];
    end
    if (adv[3]) begin
      red_sum[3] <= cond_sub(red_sum[2], sfk_pkg::TWO_PI_Q);
      red_q0[3]  <= cond_sub(red_q0[2], sfk_pkg::TWO_PI_Q);
      z_pipe[3]  <= z_pipe[2];
    end
  end

  // stage 4: fold into the cordic range
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      {out_data.neg_sum, out_data.ang_sum} <= fold(red_sum[3]);
      {out_data.neg0, out_data.ang0}       <= fold(red_q0[3]);
      out_data.pos_z                       <= z_pipe[3];
    end
  end

endmodule

`default_nettype wire

FILE: sv/sfk_cordic.sv
// ----------------------------------------------------------------------------
// sfk_cordic
// pipelined rotation-mode cordic for two lanes, then round and clamp
// ----------------------------------------------------------------------------
`default_nettype none

module sfk_cordic #(
  parameter int CORDIC_STAGES = 14
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  sfk_pkg::sfk_angles_t  in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output sfk_pkg::sfk_trig_t    out_data
);

  localparam int N  = (CORDIC_STAGES > sfk_pkg::MAX_STAGES) ?
                      sfk_pkg::MAX_STAGES : CORDIC_STAGES;
  localparam int S  = N + 1;
  localparam int AW = sfk_pkg::ANG_W;
  localparam logic signed [AW:0] RND  = 33'sd1 <<< (sfk_pkg::ANG_SHIFT - 1);
  localparam logic signed [AW:0] ONE  = (AW+1)'(sfk_pkg::ONE_Q);

  logic [S-1:0] vld;
  logic [S-1:0] vld_src;
  logic [S:0]   adv;

  // index 0 is the entering item, index k+1 is the register of stage k
  logic signed [AW-1:0]               xa [0:N];
  logic signed [AW-1:0]               ya [0:N];
  logic signed [AW-1:0]               ra [0:N];
  logic signed [AW-1:0]               xb [0:N];
  logic signed [AW-1:0]               yb [0:N];
  logic signed [AW-1:0]               rb [0:N];
  logic                               neg_a [0:N];
  logic                               neg_b [0:N];
  logic signed [sfk_pkg::FIELD_W-1:0] zp [0:N];

  function automatic logic signed [sfk_pkg::TRIG_W-1:0] round_trig(
      input logic signed [AW-1:0] v, input logic neg);
    logic signed [AW:0] t;
    logic signed [AW:0] q;
    logic signed [sfk_pkg::TRIG_W-1:0] res;
    t = neg ? (RND - (AW+1)'(v)) : ((AW+1)'(v) + RND);
    q = t >>> sfk_pkg::ANG_SHIFT;
    if (q > ONE) begin
      res = sfk_pkg::TRIG_W'(ONE);
    end else if (q < -ONE) begin
      res = sfk_pkg::TRIG_W'(-ONE);
    end else begin
      res = q[sfk_pkg::TRIG_W-1:0];
    end
    return res;
  endfunction

  assign adv[S]    = out_ready;
  assign vld_src   = {vld[S-2:0], in_valid};
  assign in_ready  = adv[0];
  assign out_valid = vld[S-1];

  for (genvar k = 0; k < S; k++) begin : g_adv
    assign adv[k] = ~vld[k] | adv[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < S; k++) begin
        if (adv[k]) begin
          vld[k] <= vld_src[k];
        end
      end
    end
  end

  assign xa[0]    = sfk_pkg::GAIN_Q;
  assign ya[0]    = '0;
  assign ra[0]    = in_data.ang_sum;
  assign xb[0]    = sfk_pkg::GAIN_Q;
  assign yb[0]    = '0;
  assign rb[0]    = in_data.ang0;
  assign neg_a[0] = in_data.neg_sum;
  assign neg_b[0] = in_data.neg0;
  assign zp[0]    = in_data.pos_z;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic signed [AW-1:0] ATAN = sfk_pkg::atan_q30(5'(k));

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        if (ra[k] >= 0) begin
          xa[k+1] <= xa[k] - (ya[k] >>> k);
          ya[k+1] <= ya[k] + (xa[k] >>> k);
          ra[k+1] <= ra[k] - ATAN;
        end else begin
          xa[k+1] <= xa[k] + (ya[k] >>> k);
          ya[k+1] <= ya[k] - (xa[k] >>> k);
          ra[k+1] <= ra[k] + ATAN;
        end
        if (rb[k] >= 0) begin
          xb[k+1] <= xb[k] - (yb[k] >>> k);
          yb[k+1] <= yb[k] + (xb[k] >>> k);
          rb[k+1] <= rb[k] - ATAN;
        end else begin
          xb[k+1] <= xb[k] + (yb[k] >>> k);
          yb[k+1] <= yb[k] - (xb[k] >>> k);
          rb[k+1] <= rb[k] + ATAN;
        end
        neg_a[k+1] <= neg_a[k];
        neg_b[k+1] <= neg_b[k];
        zp[k+1]    <= zp[k];
      end
    end
  end

  // last stage: undo the fold, round to q.frac and clamp to +-1
  always_ff @(posedge clk) begin
    if (adv[N]) begin
      out_data.cos_sum <= round_trig(xa[N], neg_a[N]);
      out_data.sin_sum <= round_trig(ya[N], neg_a[N]);
      out_data.cos0    <= round_trig(xb[N], neg_b[N]);
      out_data.sin0    <= round_trig(yb[N], neg_b[N]);
      out_data.pos_z   <= zp[N];
    end
  end

endmodule

`default_nettype wire

FILE: sv/sfk_pose.sv
// ----------------------------------------------------------------------------
// sfk_pose
// link-length products, sum, round and saturate into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module sfk_pose (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  sfk_pkg::sfk_trig_t                  in_data,
  input  wire  [sfk_pkg::LEN_W-1:0]           first_link_length,
  input  wire  [sfk_pkg::LEN_W-1:0]           second_link_length,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic signed [sfk_pkg::TRIG_W-1:0]   rot_cos,
  output logic signed [sfk_pkg::TRIG_W-1:0]   rot_sin,
  output logic signed [sfk_pkg::FIELD_W-1:0]  pos_x,
  output logic signed [sfk_pkg::FIELD_W-1:0]  pos_y,
  output logic signed [sfk_pkg::FIELD_W-1:0]  pos_z
);

  localparam int S   = 2;
  localparam int PW  = sfk_pkg::LEN_W + 1 + sfk_pkg::TRIG_W;
  localparam int ACW = PW + 1;
  localparam logic signed [ACW-1:0] RND   = ACW'(1) <<< (sfk_pkg::FRAC_BITS - 1);
  localparam logic signed [ACW-1:0] MAX_P = ACW'(32767);
  localparam logic signed [ACW-1:0] MIN_P = -ACW'(32768);

  logic [S-1:0] vld;
  logic [S-1:0] vld_src;
  logic [S:0]   adv;

  logic signed [PW-1:0]                p_xa, p_xb, p_ya, p_yb;
  logic signed [sfk_pkg::TRIG_W-1:0]   c_hold, s_hold;
  logic signed [sfk_pkg::FIELD_W-1:0]  z_hold;

  function automatic logic signed [sfk_pkg::FIELD_W-1:0] pos_sum(
      input logic signed [PW-1:0] a, input logic signed [PW-1:0] b);
    logic signed [ACW-1:0] acc;
    logic signed [ACW-1:0] q;
    logic signed [sfk_pkg::FIELD_W-1:0] res;
    acc = ACW'(a) + ACW'(b) + RND;
    q   = acc >>> sfk_pkg::FRAC_BITS;
    if (q > MAX_P) begin
      res = 16'sh7FFF;
    end else if (q < MIN_P) begin
      res = 16'sh8000;
    end else begin
      res = q[sfk_pkg::FIELD_W-1:0];
    end
    return res;
  endfunction

  assign adv[S]    = out_ready;
  assign vld_src   = {vld[S-2:0], in_valid};
  assign in_ready  = adv[0];
  assign out_valid = vld[S-1];

  for (genvar k = 0; k < S; k++) begin : g_adv
    assign adv[k] = ~vld[k] | adv[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < S; k++) begin
        if (adv[k]) begin
          vld[k] <= vld_src[k];
        end
      end
    end
  end

  // stage 0: four products, q.2frac
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p_xa   <= PW'($signed({1'b0, second_link_length})) * PW'(in_data.cos_sum);
      p_xb   <= PW'($signed({1'b0, first_link_length})) * PW'(in_data.cos0);
      p_ya   <= PW'($signed({1'b0, second_link_length})) * PW'(in_data.sin_sum);
      p_yb   <= PW'($signed({1'b0, first_link_length})) * PW'(in_data.sin0);
      c_hold <= in_data.cos_sum;
      s_hold <= in_data.sin_sum;
      z_hold <= in_data.pos_z;
    end
  end

  // stage 1: output register
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      rot_cos <= c_hold;
      rot_sin <= s_hold;
      pos_x   <= pos_sum(p_xa, p_xb);
      pos_y   <= pos_sum(p_ya, p_yb);
      pos_z   <= z_hold;
    end
  end

endmodule

`default_nettype wire

FILE: sv/scara_forward_kinematics.sv
// ----------------------------------------------------------------------------
// scara_forward_kinematics
// pose of a scara arm from two joint angles and one prismatic travel
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  joint     joint_valid / joint_ready  joint0_angle, joint1_angle, joint2_travel
//  pose      pose_valid / pose_ready    rot_cos, rot_sin, pos_x, pos_y, pos_z
//  config    cfg_wr_en                  cfg_index, cfg_data
//
//  one item per cycle while pose_ready does not stall the output; the stages are
//  five for angle reduction, one per cordic stage, one for rounding, two for
//  the link products and the output register
//  the cordic pipeline depth sets the latency, every stage is one register
//  rst clears all valid bits and loads the link lengths and height offset
//  each stage holds its item while the next one is full and held, so empty stages
//  upstream keep filling while a finished pose waits at the output
// ----------------------------------------------------------------------------
`default_nettype none

module scara_forward_kinematics #(
  parameter int CORDIC_STAGES = 14
) (
  input  wire                                     clk,
  input  wire                                     rst,
  // joint samples
  input  wire                                     joint_valid,
  output logic                                    joint_ready,
  input  wire  signed [sfk_pkg::FIELD_W-1:0]      joint0_angle,
  input  wire  signed [sfk_pkg::FIELD_W-1:0]      joint1_angle,
  input  wire  signed [sfk_pkg::FIELD_W-1:0]      joint2_travel,
  // pose results
  output logic                                    pose_valid,
  input  wire                                     pose_ready,
  output logic signed [sfk_pkg::TRIG_W-1:0]       rot_cos,
  output logic signed [sfk_pkg::TRIG_W-1:0]       rot_sin,
  output logic signed [sfk_pkg::FIELD_W-1:0]      pos_x,
  output logic signed [sfk_pkg::FIELD_W-1:0]      pos_y,
  output logic signed [sfk_pkg::FIELD_W-1:0]      pos_z,
  // configuration writes
  input  wire                                     cfg_wr_en,
  input  wire  [sfk_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire  [sfk_pkg::CFG_DATA_W-1:0]          cfg_data
);

  // configuration registers
  logic [sfk_pkg::LEN_W-1:0]          first_link_length;
  logic [sfk_pkg::LEN_W-1:0]          second_link_length;
  logic signed [sfk_pkg::FIELD_W-1:0] height_offset;

  // between pipeline sections
  logic                  red_valid, red_ready;
  sfk_pkg::sfk_angles_t  red_data;
  logic                  trig_valid, trig_ready;
  sfk_pkg::sfk_trig_t    trig_data;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      first_link_length  <= 15'd3686;
      second_link_length <= 15'd4096;
      height_offset      <= 16'sd8602;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sfk_pkg::REG_FIRST_LINK:  first_link_length  <= cfg_data[sfk_pkg::LEN_W-1:0];
        sfk_pkg::REG_SECOND_LINK: second_link_length <= cfg_data[sfk_pkg::LEN_W-1:0];
        sfk_pkg::REG_HEIGHT:      height_offset      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // angle sum, reduction modulo 2*pi, fold; z = offset - travel
  sfk_angle_reduce u_reduce (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (joint_valid),
    .in_ready      (joint_ready),
    .joint0_angle  (joint0_angle),
    .joint1_angle  (joint1_angle),
    .joint2_travel (joint2_travel),
    .height_offset (height_offset),
    .out_valid     (red_valid),
    .out_ready     (red_ready),
    .out_data      (red_data)
  );

  // cos and sin of q0+q1 and of q0
  sfk_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (red_valid),
    .in_ready  (red_ready),
    .in_data   (red_data),
    .out_valid (trig_valid),
    .out_ready (trig_ready),
    .out_data  (trig_data)
  );

  // x and y from the link lengths, output register
  sfk_pose u_pose (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (trig_valid),
    .in_ready           (trig_ready),
    .in_data            (trig_data),
    .first_link_length  (first_link_length),
    .second_link_length (second_link_length),
    .out_valid          (pose_valid),
    .out_ready          (pose_ready),
    .rot_cos            (rot_cos),
    .rot_sin            (rot_sin),
    .pos_x              (pos_x),
    .pos_y              (pos_y),
    .pos_z              (pos_z)
  );

endmodule

`default_nettype wire

FILE: tb/scara_forward_kinematics_test.sv
// ----------------------------------------------------------------------------
// scara_forward_kinematics_test
// self-checking bench for the scara pose pipeline: joint items go in through a
// bursty sender, poses come out through a receiver that stalls on a pattern of
// its own, and each pose is compared field by field with a bit-exact predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module scara_forward_kinematics_test;

  localparam int STAGES       = 14;
  // settle a good margin past the full pipeline depth
  localparam int SETTLE_CYCLES = 2 * (STAGES + 8) + 8;
  localparam int RANDOM_ITEMS  = 400;
  localparam int RANDOM_PHASES = 5;

  // register index that decodes to nothing
  localparam logic [sfk_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // angle constants in q.30 radians
  localparam longint TWO_PI_R  = 64'sd6746518852;
  localparam longint PI_R      = 64'sd3373259426;
  localparam longint HALF_PI_R = 64'sd1686629713;
  localparam longint CORDIC_K  = 64'sd652032874;
  localparam int     STAGE_CAP = 24;

  // quarter turn in q4.12, for angles near the fold points
  localparam int QUARTER_Q12 = 6434;

  localparam longint ARCTAN_Q30 [STAGE_CAP] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  typedef struct packed {
    logic signed [sfk_pkg::TRIG_W-1:0]  rot_cos;
    logic signed [sfk_pkg::TRIG_W-1:0]  rot_sin;
    logic signed [sfk_pkg::FIELD_W-1:0] pos_x;
    logic signed [sfk_pkg::FIELD_W-1:0] pos_y;
    logic signed [sfk_pkg::FIELD_W-1:0] pos_z;
  } pose_t;

  typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_t;

  // dut connections
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic joint_valid = 1'b0;
  logic joint_ready;
  logic signed [sfk_pkg::FIELD_W-1:0] joint0_angle = '0;
  logic signed [sfk_pkg::FIELD_W-1:0] joint1_angle = '0;
  logic signed [sfk_pkg::FIELD_W-1:0] joint2_travel = '0;
  logic pose_valid;
  logic pose_ready = 1'b0;
  logic signed [sfk_pkg::TRIG_W-1:0]  rot_cos;
  logic signed [sfk_pkg::TRIG_W-1:0]  rot_sin;
  logic signed [sfk_pkg::FIELD_W-1:0] pos_x;
  logic signed [sfk_pkg::FIELD_W-1:0] pos_y;
  logic signed [sfk_pkg::FIELD_W-1:0] pos_z;
  logic cfg_wr_en = 1'b0;
  logic [sfk_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sfk_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the registers
  logic [sfk_pkg::LEN_W-1:0]          model_first_len;
  logic [sfk_pkg::LEN_W-1:0]          model_second_len;
  logic signed [sfk_pkg::FIELD_W-1:0] model_height;

  pose_t pending_poses[$];
  pose_t want;

  int error_count   = 0;
  int joints_sent   = 0;
  int poses_checked = 0;
  int cfg_writes    = 0;
  int burst_left    = 0;

  ready_mode_t ready_mode = READY_ALWAYS;
  int          ready_left = 0;

  scara_forward_kinematics #(
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .joint_valid   (joint_valid),
    .joint_ready   (joint_ready),
    .joint0_angle  (joint0_angle),
    .joint1_angle  (joint1_angle),
    .joint2_travel (joint2_travel),
    .pose_valid    (pose_valid),
    .pose_ready    (pose_ready),
    .rot_cos       (rot_cos),
    .rot_sin       (rot_sin),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // pose predictor
  // --------------------------------------------------------------------------

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // cos and sin of a q4.12 angle, rounded back to q4.12 and clipped to +-1
  function automatic void angle_trig(input longint ang, output longint c, output longint s);
    longint r, x, y, nx;
    bit     flip;
    int     n;
    r    = ang <<< sfk_pkg::ANG_SHIFT;
    x    = CORDIC_K;
    y    = 0;
    flip = 1'b0;
    n    = (STAGES > STAGE_CAP) ? STAGE_CAP : STAGES;
    // floor modulo a full turn, then into [-pi, pi)
    r = r % TWO_PI_R;
    if (r < 0) r += TWO_PI_R;
    if (r >= PI_R) r -= TWO_PI_R;
    // fold the outer half turn onto the inner one, flipping both signs
    if (r > HALF_PI_R) begin
      r    -= PI_R;
      flip  = 1'b1;
    end else if (r < -HALF_PI_R) begin
      r    += PI_R;
      flip  = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        r -= ARCTAN_Q30[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        r += ARCTAN_Q30[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    x = (x + (64'sd1 <<< (sfk_pkg::ANG_SHIFT - 1))) >>> sfk_pkg::ANG_SHIFT;
    y = (y + (64'sd1 <<< (sfk_pkg::ANG_SHIFT - 1))) >>> sfk_pkg::ANG_SHIFT;
    c = clip(x, -longint'(sfk_pkg::ONE_Q), longint'(sfk_pkg::ONE_Q));
    s = clip(y, -longint'(sfk_pkg::ONE_Q), longint'(sfk_pkg::ONE_Q));
  endfunction

  // two link products summed exactly, rounded once, saturated
  function automatic longint link_reach(input longint t_sum, input longint t0);
    longint acc;
    acc = longint'(model_second_len) * t_sum + longint'(model_first_len) * t0;
    acc = (acc + (64'sd1 <<< (sfk_pkg::FRAC_BITS - 1))) >>> sfk_pkg::FRAC_BITS;
    return clip(acc, -64'sd32768, 64'sd32767);
  endfunction

  function automatic pose_t predict_pose(input logic signed [sfk_pkg::FIELD_W-1:0] q0,
                                         input logic signed [sfk_pkg::FIELD_W-1:0] q1,
                                         input logic signed [sfk_pkg::FIELD_W-1:0] q2);
    pose_t  p;
    longint c_sum, s_sum, c0, s0;
    angle_trig(longint'(q0) + longint'(q1), c_sum, s_sum);
    angle_trig(longint'(q0), c0, s0);
    p.rot_cos = c_sum[sfk_pkg::TRIG_W-1:0];
    p.rot_sin = s_sum[sfk_pkg::TRIG_W-1:0];
    p.pos_x   = sfk_pkg::FIELD_W'(link_reach(c_sum, c0));
    p.pos_y   = sfk_pkg::FIELD_W'(link_reach(s_sum, s0));
    p.pos_z   = sfk_pkg::FIELD_W'(clip(longint'(model_height) - longint'(q2),
                                       -64'sd32768, 64'sd32767));
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // register write, dut must be idle
  task automatic write_reg(input logic [sfk_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sfk_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      sfk_pkg::REG_FIRST_LINK:  model_first_len  = data[sfk_pkg::LEN_W-1:0];
      sfk_pkg::REG_SECOND_LINK: model_second_len = data[sfk_pkg::LEN_W-1:0];
      sfk_pkg::REG_HEIGHT:      model_height     = data;
      default: ;  // unknown index, nothing changes
    endcase
    cfg_writes++;
  endtask

  task automatic set_arm(input logic [sfk_pkg::CFG_DATA_W-1:0] first_len,
                         input logic [sfk_pkg::CFG_DATA_W-1:0] second_len,
                         input logic [sfk_pkg::CFG_DATA_W-1:0] height);
    write_reg(sfk_pkg::REG_FIRST_LINK, first_len);
    write_reg(sfk_pkg::REG_SECOND_LINK, second_len);
    write_reg(sfk_pkg::REG_HEIGHT, height);
  endtask

  // one joint item; the sender may idle between bursts of random length
  task automatic send_joint(input logic signed [sfk_pkg::FIELD_W-1:0] q0,
                            input logic signed [sfk_pkg::FIELD_W-1:0] q1,
                            input logic signed [sfk_pkg::FIELD_W-1:0] q2);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        joint_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    joint_valid   <= 1'b1;
    joint0_angle  <= q0;
    joint1_angle  <= q1;
    joint2_travel <= q2;
    do @(posedge clk); while (!joint_ready);
    pending_poses.insert(pending_poses.size(), predict_pose(q0, q1, q2));
    joints_sent++;
  endtask

  // stop sending and wait for every pose, then let the pipeline settle
  task automatic drain_poses();
    @(negedge clk);
    joint_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver stalls: modes change at random intervals
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_left = $urandom_range(16, 128);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      READY_ALWAYS:   pose_ready <= 1'b1;
      READY_COIN:     pose_ready <= ($urandom_range(0, 1) == 1);
      READY_SPARSE:   pose_ready <= ($urandom_range(0, 3) == 0);
      READY_PERIODIC: pose_ready <= (ready_left % 5) != 0;
      default:        pose_ready <= 1'b1;
    endcase
  end

  // --------------------------------------------------------------------------
  // pose checker
  // --------------------------------------------------------------------------

  task automatic check_field(input string name,
                             input logic signed [sfk_pkg::FIELD_W-1:0] expected,
                             input logic signed [sfk_pkg::FIELD_W-1:0] actual);
    if (actual !== expected) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pose_valid && pose_ready) begin
      if (pending_poses.size() == 0) begin
        $error("pose item with no joint item outstanding");
        error_count++;
      end else begin
        want = pending_poses.pop_front();
        check_field("rot_cos", sfk_pkg::FIELD_W'(want.rot_cos), sfk_pkg::FIELD_W'(rot_cos));
        check_field("rot_sin", sfk_pkg::FIELD_W'(want.rot_sin), sfk_pkg::FIELD_W'(rot_sin));
        check_field("pos_x", want.pos_x, pos_x);
        check_field("pos_y", want.pos_y, pos_y);
        check_field("pos_z", want.pos_z, pos_z);
        poses_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // field extremes under the reset arm, also checks the reset register values
  task automatic test_reset_arm();
    send_joint(16'sd0, 16'sd0, 16'sd0);
    send_joint(16'sd32767, 16'sd0, 16'sd32767);
    send_joint(-16'sd32768, 16'sd0, -16'sd32768);   // pos_z saturates high
    send_joint(16'sd0, 16'sd32767, -16'sd1);
    send_joint(16'sd32767, 16'sd32767, 16'sd1);      // largest angle sum
    send_joint(-16'sd32768, -16'sd32768, 16'sd0);    // most negative sum
    send_joint(-16'sd1, -16'sd1, 16'sh5555);
    send_joint(16'sh5555, 16'shAAAA, 16'shAAAA);
    drain_poses();
  endtask

  // angles on both sides of the quarter and half turn folds and of a full turn
  task automatic test_angle_folds();
    send_joint(sfk_pkg::FIELD_W'(QUARTER_Q12 - 1), 16'sd0, 16'sd0);
    send_joint(sfk_pkg::FIELD_W'(QUARTER_Q12), 16'sd0, 16'sd0);
    send_joint(sfk_pkg::FIELD_W'(-QUARTER_Q12 + 1), 16'sd0, 16'sd0);
    send_joint(sfk_pkg::FIELD_W'(-QUARTER_Q12), 16'sd0, 16'sd0);
    send_joint(16'sd0, sfk_pkg::FIELD_W'(2 * QUARTER_Q12 - 1), 16'sd0);
    send_joint(16'sd0, sfk_pkg::FIELD_W'(2 * QUARTER_Q12), 16'sd0);
    send_joint(sfk_pkg::FIELD_W'(-2 * QUARTER_Q12), 16'sd0, 16'sd0);
    send_joint(sfk_pkg::FIELD_W'(4 * QUARTER_Q12 - 1), 16'sd0, 16'sd0);
    send_joint(sfk_pkg::FIELD_W'(4 * QUARTER_Q12), 16'sd1, 16'sd0);
    drain_poses();
  endtask

  // register extremes: saturating reach and height, zero links, masking
  task automatic test_register_limits();
    set_arm(16'd32767, 16'd32767, 16'h8000);
    send_joint(16'sd0, 16'sd0, 16'sd32767);            // x and z saturate
    send_joint(sfk_pkg::FIELD_W'(2 * QUARTER_Q12), 16'sd0, -16'sd32768);  // x saturates low
    send_joint(sfk_pkg::FIELD_W'(QUARTER_Q12), 16'sd0, 16'sd0);
    drain_poses();
    set_arm(16'd0, 16'd0, 16'h7FFF);
    send_joint(16'sd1234, -16'sd4321, -16'sd1);        // z saturates high
    drain_poses();
    // bit 15 falls off a link register; an unknown index changes nothing
    write_reg(sfk_pkg::REG_FIRST_LINK, 16'hFFFF);
    write_reg(sfk_pkg::REG_SECOND_LINK, 16'h8000);
    write_reg(REG_UNUSED, 16'h1234);
    send_joint(16'sd100, 16'sd200, 16'sd300);
    send_joint(-16'sd7000, 16'sd3000, 16'sd0);
    drain_poses();
  endtask

  function automatic logic signed [sfk_pkg::FIELD_W-1:0] pick_angle();
    case ($urandom_range(0, 3))
      0: return sfk_pkg::FIELD_W'($urandom_range(0, 16'hFFFF));
      1: return sfk_pkg::FIELD_W'($signed($urandom_range(0, 16383)) - 8192);
      2: return sfk_pkg::FIELD_W'(($signed($urandom_range(0, 10)) - 5) * QUARTER_Q12
                                  + $signed($urandom_range(0, 6)) - 3);
      default: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  function automatic logic [sfk_pkg::CFG_DATA_W-1:0] pick_link();
    return ($urandom_range(0, 3) == 0) ? sfk_pkg::CFG_DATA_W'($urandom_range(0, 16'hFFFF))
                                       : sfk_pkg::CFG_DATA_W'($urandom_range(2048, 8192));
  endfunction

  // random joints, arm geometry changed between phases
  task automatic test_random_poses();
    logic signed [sfk_pkg::FIELD_W-1:0] travel;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 1)
        set_arm(16'd3686, 16'd4096, 16'd8602);
      else if (phase == RANDOM_PHASES - 1)
        set_arm(16'd32767, 16'd32767, sfk_pkg::CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
      else
        set_arm(pick_link(), pick_link(), sfk_pkg::CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
      for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) begin
        travel = ($urandom_range(0, 1) == 0)
                 ? sfk_pkg::FIELD_W'($urandom_range(0, 16'hFFFF))
                 : sfk_pkg::FIELD_W'($signed($urandom_range(0, 8191)) - 4096);
        send_joint(pick_angle(), pick_angle(), travel);
      end
      drain_poses();
    end
  endtask

  initial begin
    model_first_len  = 15'd3686;
    model_second_len = 15'd4096;
    model_height     = 16'sd8602;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_arm();
    test_angle_folds();
    test_register_limits();
    test_random_poses();
    $display("covered %0d joint items, %0d poses checked, %0d register writes",
             joints_sent, poses_checked, cfg_writes);
    $display("fold points, angle wrap, reach and height saturation, bursty and stalled flow");
    if (error_count == 0 && pending_poses.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
